/* rtl/udec_pkg.sv */
package udec_pkg;

  typedef enum logic [3:0] {
    ST_ACCEPT  = 4'd0,
    ST_REJECT  = 4'd1,
    ST_NEED1   = 4'd2,
    ST_NEED2   = 4'd3,
    ST_AFT_E0  = 4'd4,
    ST_AFT_ED  = 4'd5,
    ST_AFT_F0  = 4'd6,
    ST_AFT_F13 = 4'd7,
    ST_AFT_F4  = 4'd8
  } st_e;

  typedef enum logic [0:0] {
    REG_DROP_C1 = 1'b0
  } reg_idx_e;

  localparam int unsigned CpW     = 21;
  localparam int unsigned NumCls  = 12;
  localparam int unsigned NumSt   = 9;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpW-1:0] C1Lo        = 21'h000080;
  localparam logic [CpW-1:0] C1Hi        = 21'h00009F;
  localparam logic [7:0]     PayloadMask = 8'h3F;
  localparam logic [7:0]     LeadMask    = 8'hFF;

  // next state, [state][byte class]
  localparam logic [0:NumSt-1][0:NumCls-1][3:0] NextTab = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
  };

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_repl;
    logic           last;
  } res_t;

  typedef struct packed {
    logic [1:0] vld;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80)       c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd9;
    else if (b < 8'hC0)  c = 4'd7;
    else if (b < 8'hC2)  c = 4'd8;
    else if (b < 8'hE0)  c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0)  c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4)  c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

  function automatic st_e next_st(input st_e s, input logic [3:0] cls);
    st_e r;
    if (s > ST_AFT_F4 || cls >= 4'(NumCls)) r = ST_REJECT;
    else r = st_e'(NextTab[s][cls]);
    return r;
  endfunction

endpackage

/* rtl/utf8_stream_decoder.sv */
// channel | dir | handshake                | payload
// in      | in  | in_valid_i / in_stall_o  | in_byte_i[7:0]
// out     | out | out_valid_o / out_stall_i| out_code_point_o[20:0], out_is_replacement_o,
//         |     |                          | out_last_o
// cfg     | in  | APB psel/penable/pready  | drop_control_c1 at address 0
//
// One byte per cycle while the queue has room; an accepted byte waits in the
// byte register for room; its results then enter the queue and can leave at the following edge.
// Rate is set by the 4-entry result queue: a byte that yields two results
// takes two queue entries and may stall input.
// Reset: decoder in accept state, queue empty, drop_control_c1 = 1.
// in_stall_o depends only on registered state.
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] out_code_point_o,
  output logic        out_is_replacement_o,
  output logic        out_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             drop_q, drop_d;
  logic             reg_sel, cfg_wr;
  logic             room;
  udec_pkg::push_t  push;
  udec_pkg::res_t   head;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == udec_pkg::REG_DROP_C1;
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign drop_d  = cfg_wr ? pwdata[0] : drop_q;
  assign prdata  = reg_sel ? {31'd0, drop_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b1;
    end else begin
      drop_q <= drop_d;
    end
  end

  udec_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .drop_c1_i  (drop_q),
    .room_i     (room),
    .push_o     (push)
  );

  udec_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign out_code_point_o     = head.code_point;
  assign out_is_replacement_o = head.is_repl;
  assign out_last_o           = head.last;

  a_two_first_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.vld[1] |-> push.vld[0] && push.r0.is_repl && !push.r0.last)
    else $error("second result without leading replacement");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.vld[0] |-> $past(room) || room)
    else $error("result pushed without queue room");

  a_nonlast_is_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> out_is_replacement_o)
    else $error("non-final result is not a replacement");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> drop_q == $past(pwdata[0]))
    else $error("drop_control_c1 write lost");

endmodule

/* rtl/udec_step.sv */
module udec_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  output logic                in_stall_o,
  input  logic                drop_c1_i,
  input  logic                room_i,
  output udec_pkg::push_t     push_o
);

  logic                       vld_q, vld_d;
  logic [7:0]                 byte_q;
  udec_pkg::st_e              st_q, st_d;
  logic [udec_pkg::CpW-1:0]   pv_q, pv_d;

  logic                       fire;
  logic [3:0]                 cls;
  logic [7:0]                 lead_bits;
  udec_pkg::st_e              s1, ns1, ns2;
  logic [udec_pkg::CpW-1:0]   pv1, pv2;
  logic                       drop1, drop2;

  assign fire       = vld_q && room_i;
  assign in_stall_o = vld_q && !room_i;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && !in_stall_o) begin
      vld_d = 1'b1;
    end else if (fire) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      st_q  <= udec_pkg::ST_ACCEPT;
      pv_q  <= '0;
    end else begin
      vld_q <= vld_d;
      st_q  <= st_d;
      pv_q  <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= in_byte_i;
    end
  end

  // both DFA passes side by side; the second starts from the accept state
  always_comb begin
    cls       = udec_pkg::byte_class(byte_q);
    lead_bits = (udec_pkg::LeadMask >> cls) & byte_q;
    s1        = (st_q > udec_pkg::ST_AFT_F4) ? udec_pkg::ST_ACCEPT : st_q;
    pv2       = {13'd0, lead_bits};
    if (s1 != udec_pkg::ST_ACCEPT) begin
      pv1 = {pv_q[udec_pkg::CpW-7:0], byte_q[5:0] & udec_pkg::PayloadMask[5:0]};
    end else begin
      pv1 = pv2;
    end
    ns1   = udec_pkg::next_st(s1, cls);
    ns2   = udec_pkg::next_st(udec_pkg::ST_ACCEPT, cls);
    drop1 = drop_c1_i && pv1 >= udec_pkg::C1Lo && pv1 <= udec_pkg::C1Hi;
    drop2 = drop_c1_i && pv2 >= udec_pkg::C1Lo && pv2 <= udec_pkg::C1Hi;
  end

  // next state
  always_comb begin
    st_d = st_q;
    pv_d = pv_q;
    if (fire) begin
      if (ns1 == udec_pkg::ST_ACCEPT) begin
        st_d = udec_pkg::ST_ACCEPT;
        pv_d = '0;
      end else if (ns1 == udec_pkg::ST_REJECT) begin
        if (s1 != udec_pkg::ST_ACCEPT && ns2 != udec_pkg::ST_ACCEPT &&
            ns2 != udec_pkg::ST_REJECT) begin
          st_d = ns2;
          pv_d = pv2;
        end else begin
          st_d = udec_pkg::ST_ACCEPT;
          pv_d = '0;
        end
      end else begin
        st_d = ns1;
        pv_d = pv1;
      end
    end
  end

  // results
  always_comb begin
    push_o                  = '0;
    push_o.r0.code_point    = pv1;
    push_o.r1.code_point    = pv2;
    push_o.r1.last          = 1'b1;
    if (fire) begin
      if (ns1 == udec_pkg::ST_ACCEPT) begin
        push_o.vld[0]       = !drop1;
        push_o.r0.last      = 1'b1;
      end else if (ns1 == udec_pkg::ST_REJECT) begin
        push_o.vld[0]            = 1'b1;
        push_o.r0.code_point     = udec_pkg::Replacement;
        push_o.r0.is_repl        = 1'b1;
        push_o.r0.last           = 1'b1;
        if (s1 != udec_pkg::ST_ACCEPT) begin
          if (ns2 == udec_pkg::ST_ACCEPT && !drop2) begin
            push_o.vld[1]        = 1'b1;
            push_o.r0.last       = 1'b0;
          end else if (ns2 == udec_pkg::ST_REJECT) begin
            push_o.vld[1]        = 1'b1;
            push_o.r0.last       = 1'b0;
            push_o.r1.code_point = udec_pkg::Replacement;
            push_o.r1.is_repl    = 1'b1;
          end
        end
      end
    end
  end

endmodule

/* rtl/udec_outbuf.sv */
module udec_outbuf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  udec_pkg::push_t          push_i,
  output logic                     room_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output udec_pkg::res_t           head_o
);

  udec_pkg::res_t                  mem_q [udec_pkg::QDepth];
  logic [udec_pkg::QPtrW-1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [udec_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            pop;
  logic [udec_pkg::QPtrW-1:0]      wp1;
  logic [udec_pkg::QCntW-1:0]      n_push;

  assign room_o      = cnt_q <= udec_pkg::QCntW'(udec_pkg::QDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rp_q];
  assign wp1         = wp_q + 1'b1;

  always_comb begin
    n_push = udec_pkg::QCntW'(push_i.vld[0]) + udec_pkg::QCntW'(push_i.vld[1]);
    wp_d   = wp_q + n_push[udec_pkg::QPtrW-1:0];
    rp_d   = pop ? rp_q + 1'b1 : rp_q;
    cnt_d  = cnt_q + n_push - udec_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld[0]) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.vld[1]) begin
      mem_q[wp1] <= push_i.r1;
    end
  end

endmodule
